[sv/ppt_pkg.sv]
// shared types and constants for the point projective transform
`timescale 1ns / 1ps

package ppt_pkg;

    // default fixed point fraction width
    localparam int FRAC_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_SCALE     = 3'd1;
    localparam logic [2:0] CFG_SKEW      = 3'd2;
    localparam logic [2:0] CFG_TRANSLATE = 3'd3;
    localparam logic [2:0] CFG_PERSP     = 3'd4;
    localparam logic [2:0] CFG_BIAS      = 3'd5;

    // transform forms
    localparam logic [1:0] MODE_TRANSLATE   = 2'd0;
    localparam logic [1:0] MODE_SCALE       = 2'd1;
    localparam logic [1:0] MODE_AFFINE      = 2'd2;
    localparam logic [1:0] MODE_PERSPECTIVE = 2'd3;

    // per-item data that rides alongside the divider pipelines
    typedef struct packed {
        logic        persp;
        logic        w_zero;
        logic        neg_x;
        logic        neg_y;
        logic        clip_byp;
        logic        last;
        logic [31:0] x_byp;
        logic [31:0] y_byp;
    } ppt_side_t;

endpackage

[sv/ppt_div.sv]
// pipelined restoring divider, one quotient bit per stage, saturation flag
`timescale 1ns / 1ps

module ppt_div
    import ppt_pkg::*;
#(
    parameter int NUM_W     = 50,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_mag,
    input  logic [NUM_W-1:0] den_mag,
    output logic [31:0]      quo,
    output logic             ovf
);

    localparam int RW = NUM_W + 32;

    logic [RW-1:0]    rem_reg [0:32];
    logic [NUM_W-1:0] den_reg [0:32];
    logic [31:0]      q_reg   [0:32];
    logic             ovf_reg [0:32];

    logic [RW-1:0] dividend;
    assign dividend = RW'({num_mag, {FRAC_BITS{1'b0}}});

    // entry stage: scale the dividend and check for a quotient of 2^32 or more
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= dividend;
            den_reg[0] <= den_mag;
            q_reg[0]   <= 32'd0;
            ovf_reg[0] <= (dividend >= {den_mag, 32'd0});
        end
    end

    // one quotient bit per stage, most significant first
    genvar g;
    generate
        for (g = 0; g < 32; g++) begin : g_stage
            logic [RW-1:0] sh;
            logic          ge;
            assign sh = RW'(den_reg[g]) << (31 - g);
            assign ge = (rem_reg[g] >= sh);
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g+1] <= ge ? (rem_reg[g] - sh) : rem_reg[g];
                    den_reg[g+1] <= den_reg[g];
                    q_reg[g+1]   <= q_reg[g] | (ge ? (32'd1 << (31 - g)) : 32'd0);
                    ovf_reg[g+1] <= ovf_reg[g];
                end
            end
        end
    endgenerate

    assign quo = q_reg[32];
    assign ovf = ovf_reg[32];

endmodule

[sv/point_projective_transform.sv]
// top level: 2d homogeneous point transform through a 3x3 matrix
// pipeline from input transaction to m_axis_tvalid:
//   input, multiply, sum, sign stages, 33 divider stages, output register
// throughput: one point per cycle; the whole pipeline holds while the output waits
// reset: aresetn clears all valid bits and loads the identity-like defaults
`timescale 1ns / 1ps

module point_projective_transform
    import ppt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // x_in [31:0], y_in [63:32]
    input  logic        s_axis_tlast,   // last_point
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // x_out [31:0], y_out [63:32]
    output logic [1:0]  m_axis_tuser,   // w_zero [0], clipped [1]
    output logic        m_axis_tlast    // last_out
);

    localparam int NUM_W = 66 - FRAC_BITS;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [63:0] scale_reg, skew_reg, trans_reg, persp_reg;
    logic [31:0] bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_AFFINE;
            scale_reg <= {32'(64'd1 << FRAC_BITS), 32'(64'd1 << FRAC_BITS)};
            skew_reg  <= 64'd0;
            trans_reg <= 64'd0;
            persp_reg <= 64'd0;
            bias_reg  <= 32'(64'd1 << FRAC_BITS);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE:      mode_reg  <= cfg_wdata[1:0];
                CFG_SCALE:     scale_reg <= cfg_wdata;
                CFG_SKEW:      skew_reg  <= cfg_wdata;
                CFG_TRANSLATE: trans_reg <= cfg_wdata;
                CFG_PERSP:     persp_reg <= cfg_wdata;
                CFG_BIAS:      bias_reg  <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] sx, sy, kx, ky, tx, ty, p0, p1, p2;
    assign sx = signed'(scale_reg[31:0]);
    assign sy = signed'(scale_reg[63:32]);
    assign kx = signed'(skew_reg[31:0]);
    assign ky = signed'(skew_reg[63:32]);
    assign tx = signed'(trans_reg[31:0]);
    assign ty = signed'(trans_reg[63:32]);
    assign p0 = signed'(persp_reg[31:0]);
    assign p1 = signed'(persp_reg[63:32]);
    assign p2 = signed'(bias_reg);

    // global advance: the pipeline moves when the output register is empty or its result is being taken
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic vd_reg [0:32];
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 33; i++) vd_reg[i] <= 1'b0;
        end else if (en) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vd_reg[0] <= v4_reg;
            for (int i = 1; i < 33; i++) vd_reg[i] <= vd_reg[i-1];
            m_valid_reg <= vd_reg[32];
        end
    end

    // stage 1: input capture
    logic signed [31:0] x1_reg, y1_reg;
    logic               last1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= signed'(s_axis_tdata[31:0]);
            y1_reg    <= signed'(s_axis_tdata[63:32]);
            last1_reg <= s_axis_tlast;
        end
    end

    // stage 2: all six products
    logic signed [63:0] pxs_reg, pyk_reg, pxk_reg, pys_reg, px0_reg, py1_reg;
    logic signed [31:0] x2_reg, y2_reg;
    logic               last2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxs_reg   <= x1_reg * sx;
            pyk_reg   <= y1_reg * kx;
            pxk_reg   <= x1_reg * ky;
            pys_reg   <= y1_reg * sy;
            px0_reg   <= x1_reg * p0;
            py1_reg   <= y1_reg * p1;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            last2_reg <= last1_reg;
        end
    end

    // stage 3: floor the products and sum the numerators and w
    logic signed [NUM_W-1:0] fxs, fyk, fxk, fys, fx0, fy1;
    logic signed [NUM_W-1:0] nx_next, ny_next, w_next;
    logic signed [63:0]      sh_xs, sh_yk, sh_xk, sh_ys, sh_x0, sh_y1;

    assign sh_xs = pxs_reg >>> FRAC_BITS;
    assign sh_yk = pyk_reg >>> FRAC_BITS;
    assign sh_xk = pxk_reg >>> FRAC_BITS;
    assign sh_ys = pys_reg >>> FRAC_BITS;
    assign sh_x0 = px0_reg >>> FRAC_BITS;
    assign sh_y1 = py1_reg >>> FRAC_BITS;
    assign fxs = signed'(sh_xs[NUM_W-1:0]);
    assign fyk = signed'(sh_yk[NUM_W-1:0]);
    assign fxk = signed'(sh_xk[NUM_W-1:0]);
    assign fys = signed'(sh_ys[NUM_W-1:0]);
    assign fx0 = signed'(sh_x0[NUM_W-1:0]);
    assign fy1 = signed'(sh_y1[NUM_W-1:0]);

    always_comb begin
        w_next = fx0 + fy1 + NUM_W'(p2);
        case (mode_reg)
            MODE_TRANSLATE: begin
                nx_next = NUM_W'(x2_reg) + NUM_W'(tx);
                ny_next = NUM_W'(y2_reg) + NUM_W'(ty);
            end
            MODE_SCALE: begin
                nx_next = fxs + NUM_W'(tx);
                ny_next = fys + NUM_W'(ty);
            end
            default: begin
                nx_next = fxs + fyk + NUM_W'(tx);
                ny_next = fxk + fys + NUM_W'(ty);
            end
        endcase
    end

    logic signed [NUM_W-1:0] nx3_reg, ny3_reg, w3_reg;
    logic                    last3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx3_reg   <= nx_next;
            ny3_reg   <= ny_next;
            w3_reg    <= w_next;
            last3_reg <= last2_reg;
        end
    end

    // stage 4: magnitudes and signs for the divider, saturation for the direct path
    logic       fit_x, fit_y;
    ppt_side_t  side_next;
    logic [NUM_W-1:0] nmx_next, nmy_next, dm_next;

    assign fit_x = (&nx3_reg[NUM_W-1:31]) || !(|nx3_reg[NUM_W-1:31]);
    assign fit_y = (&ny3_reg[NUM_W-1:31]) || !(|ny3_reg[NUM_W-1:31]);

    always_comb begin
        side_next.persp    = (mode_reg == MODE_PERSPECTIVE);
        side_next.w_zero   = (w3_reg == '0);
        side_next.neg_x    = nx3_reg[NUM_W-1] ^ w3_reg[NUM_W-1];
        side_next.neg_y    = ny3_reg[NUM_W-1] ^ w3_reg[NUM_W-1];
        side_next.clip_byp = !fit_x || !fit_y;
        side_next.last     = last3_reg;
        side_next.x_byp    = fit_x ? nx3_reg[31:0]
                           : (nx3_reg[NUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        side_next.y_byp    = fit_y ? ny3_reg[31:0]
                           : (ny3_reg[NUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        nmx_next = nx3_reg[NUM_W-1] ? unsigned'(-nx3_reg) : unsigned'(nx3_reg);
        nmy_next = ny3_reg[NUM_W-1] ? unsigned'(-ny3_reg) : unsigned'(ny3_reg);
        dm_next  = w3_reg[NUM_W-1] ? unsigned'(-w3_reg) : unsigned'(w3_reg);
    end

    ppt_side_t        side4_reg;
    logic [NUM_W-1:0] nmx4_reg, nmy4_reg, dm4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side4_reg <= side_next;
            nmx4_reg  <= nmx_next;
            nmy4_reg  <= nmy_next;
            dm4_reg   <= dm_next;
        end
    end

    // divider pipelines, one per coordinate
    logic [31:0] qx, qy;
    logic        ovx, ovy;

    ppt_div #(.NUM_W(NUM_W), .FRAC_BITS(FRAC_BITS)) u_div_x (
        .aclk    (aclk),
        .en      (en),
        .num_mag (nmx4_reg),
        .den_mag (dm4_reg),
        .quo     (qx),
        .ovf     (ovx)
    );

    ppt_div #(.NUM_W(NUM_W), .FRAC_BITS(FRAC_BITS)) u_div_y (
        .aclk    (aclk),
        .en      (en),
        .num_mag (nmy4_reg),
        .den_mag (dm4_reg),
        .quo     (qy),
        .ovf     (ovy)
    );

    // sideband delay line matched to the divider
    ppt_side_t sb_reg [0:32];

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= side4_reg;
            for (int i = 1; i < 33; i++) sb_reg[i] <= sb_reg[i-1];
        end
    end

    // final saturation, sign and result selection
    ppt_side_t   sb;
    logic [32:0] lim_x, lim_y;
    logic        big_x, big_y;
    logic [32:0] mag_x, mag_y;
    logic [31:0] xo_next, yo_next;
    logic        wz_next, clip_next;

    assign sb = sb_reg[32];

    always_comb begin
        lim_x = sb.neg_x ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        lim_y = sb.neg_y ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        big_x = ovx || ({1'b0, qx} > lim_x);
        big_y = ovy || ({1'b0, qy} > lim_y);
        mag_x = big_x ? lim_x : {1'b0, qx};
        mag_y = big_y ? lim_y : {1'b0, qy};
        if (!sb.persp) begin
            xo_next   = sb.x_byp;
            yo_next   = sb.y_byp;
            wz_next   = 1'b0;
            clip_next = sb.clip_byp;
        end else if (sb.w_zero) begin
            xo_next   = 32'd0;
            yo_next   = 32'd0;
            wz_next   = 1'b1;
            clip_next = 1'b0;
        end else begin
            xo_next   = sb.neg_x ? 32'(-mag_x) : mag_x[31:0];
            yo_next   = sb.neg_y ? 32'(-mag_y) : mag_y[31:0];
            wz_next   = 1'b0;
            clip_next = big_x || big_y;
        end
    end

    // output register
    logic [31:0] xo_reg, yo_reg;
    logic        wz_reg, clip_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xo_reg   <= xo_next;
            yo_reg   <= yo_next;
            wz_reg   <= wz_next;
            clip_reg <= clip_next;
            last_reg <= sb.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {yo_reg, xo_reg};
    assign m_axis_tuser  = {clip_reg, wz_reg};
    assign m_axis_tlast  = last_reg;

endmodule

[dv/point_projective_transform_test.sv]
// testbench for the point projective transform: directed table, random phases, self-checking
`timescale 1ns / 1ps

module point_projective_transform_test
    import ppt_pkg::*;
();

    localparam int FB = FRAC_BITS_DEF;
    localparam int PIPE_LAT = 38;
    localparam logic ROW_CFG = 1'b0;
    localparam logic ROW_PT  = 1'b1;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        wz;
        logic        clip;
        logic        last;
    } point_res_t;

    typedef struct {
        logic        kind;
        logic [2:0]  idx;
        logic [63:0] data;
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        logic        typed;
        point_res_t  res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // x_in [31:0], y_in [63:32]
    logic        s_axis_tlast = 1'b0; // last_point
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // x_out [31:0], y_out [63:32]
    logic [1:0]  m_axis_tuser;        // w_zero [0], clipped [1]
    logic        m_axis_tlast;

    // local copy of the matrix registers
    logic [1:0]  cur_mode;
    logic [63:0] cur_scale, cur_skew, cur_trans, cur_persp;
    logic [31:0] cur_bias;

    point_res_t  pending_pts[$];
    stim_row_t   dir_tab[$];
    int          err_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    point_projective_transform u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // floored fixed point product
    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FB;
    endfunction

    function automatic logic [31:0] clamp32(longint v, inout logic clip);
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // num / w with fraction bits, truncated toward zero, saturated
    function automatic logic [31:0] fx_div(longint num, longint w, inout logic clip);
        logic neg;
        longint unsigned n, d, lim, q, r;
        neg = (num < 0) != (w < 0);
        n = (num < 0) ? longint'(-num) : num;
        d = (w < 0) ? longint'(-w) : w;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q = n / d;
        r = n % d;
        if (q > lim) begin
            clip = 1'b1;
            q = lim;
        end else begin
            for (int i = 0; i < FB; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 1;
                end
            end
            if (q > lim) begin
                clip = 1'b1;
                q = lim;
            end
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic point_res_t map_point(logic [31:0] xi, logic [31:0] yi, logic li);
        point_res_t r;
        longint x, y, sx, sy, kx, ky, tx, ty, nx, ny, w;
        logic clip;
        x = longint'(signed'(xi));
        y = longint'(signed'(yi));
        sx = longint'(signed'(cur_scale[31:0]));
        sy = longint'(signed'(cur_scale[63:32]));
        kx = longint'(signed'(cur_skew[31:0]));
        ky = longint'(signed'(cur_skew[63:32]));
        tx = longint'(signed'(cur_trans[31:0]));
        ty = longint'(signed'(cur_trans[63:32]));
        clip = 1'b0;
        r.wz = 1'b0;
        r.last = li;
        case (cur_mode)
            MODE_TRANSLATE: begin
                nx = x + tx;
                ny = y + ty;
            end
            MODE_SCALE: begin
                nx = fx_mul(x, sx) + tx;
                ny = fx_mul(y, sy) + ty;
            end
            default: begin
                nx = fx_mul(x, sx) + fx_mul(y, kx) + tx;
                ny = fx_mul(x, ky) + fx_mul(y, sy) + ty;
            end
        endcase
        if (cur_mode == MODE_PERSPECTIVE) begin
            w = fx_mul(x, longint'(signed'(cur_persp[31:0])))
                + fx_mul(y, longint'(signed'(cur_persp[63:32])))
                + longint'(signed'(cur_bias));
            if (w == 0) begin
                r.wz = 1'b1;
                r.x = '0;
                r.y = '0;
            end else begin
                r.x = fx_div(nx, w, clip);
                r.y = fx_div(ny, w, clip);
            end
        end else begin
            r.x = clamp32(nx, clip);
            r.y = clamp32(ny, clip);
        end
        r.clip = clip;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // result channel back-pressure
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        point_res_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_pts.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata[31:0], '0);
            end else begin
                e = pending_pts.pop_front();
                if (m_axis_tdata[31:0] !== e.x) report_mismatch("x_out", m_axis_tdata[31:0], e.x);
                if (m_axis_tdata[63:32] !== e.y)
                    report_mismatch("y_out", m_axis_tdata[63:32], e.y);
                if (m_axis_tuser[0] !== e.wz) report_mismatch("w_zero", m_axis_tuser[0], e.wz);
                if (m_axis_tuser[1] !== e.clip) report_mismatch("clipped", m_axis_tuser[1], e.clip);
                if (m_axis_tlast !== e.last) report_mismatch("last_out", m_axis_tlast, e.last);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MODE:      cur_mode = val[1:0];
            CFG_SCALE:     cur_scale = val;
            CFG_SKEW:      cur_skew = val;
            CFG_TRANSLATE: cur_trans = val;
            CFG_PERSP:     cur_persp = val;
            CFG_BIAS:      cur_bias = val[31:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // push one point, expectation recorded at the accepting edge
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic l, logic typed,
                              point_res_t fixed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        s_axis_tlast <= l;
        do @(posedge aclk); while (!s_axis_tready);
        pending_pts.push_back(typed ? fixed : map_point(x, y, l));
    endtask

    // let the pipeline empty before touching registers
    task automatic drain_pipe();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 8) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            6: return $urandom;
            7: return 32'h7FFF_FFFF;
            8: return 32'h8000_0000;
            9: return 32'h0001_0000;
            default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
    endfunction

    function automatic stim_row_t cfg_row(logic [2:0] idx, logic [63:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = val;
        return r;
    endfunction

    function automatic stim_row_t pt_row(logic [31:0] x, logic [31:0] y, logic l, logic typed,
                                         logic [31:0] ex, logic [31:0] ey, logic ewz,
                                         logic eclip);
        stim_row_t r;
        r = '{default: '0};
        r.kind = ROW_PT;
        r.x = x;
        r.y = y;
        r.last = l;
        r.typed = typed;
        r.res.x = ex;
        r.res.y = ey;
        r.res.wz = ewz;
        r.res.clip = eclip;
        r.res.last = l;
        return r;
    endfunction

    // stimulus
    initial begin
        cur_mode = MODE_AFFINE;
        cur_scale = 64'h0001_0000_0001_0000;
        cur_skew = '0;
        cur_trans = '0;
        cur_persp = '0;
        cur_bias = 32'h0001_0000;

        // identity after reset, extremes pass through
        dir_tab.push_back(pt_row(32'h0, 32'h0, 1, 1, 32'h0, 32'h0, 0, 0));
        dir_tab.push_back(pt_row(32'h7FFF_FFFF, 32'h8000_0000, 0, 1,
                                 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        dir_tab.push_back(pt_row(32'h8000_0000, 32'h7FFF_FFFF, 1, 1,
                                 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
        dir_tab.push_back(pt_row(32'h0001_2345, 32'hFFFF_5433, 0, 0, 0, 0, 0, 0));
        // translate with saturation both ways
        dir_tab.push_back(cfg_row(CFG_MODE, MODE_TRANSLATE));
        dir_tab.push_back(cfg_row(CFG_TRANSLATE, 64'h8000_0000_7FFF_FFFF));
        dir_tab.push_back(pt_row(32'h7FFF_FFFF, 32'h0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1));
        dir_tab.push_back(pt_row(32'h0, 32'h8000_0000, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1));
        // scale with extreme factors
        dir_tab.push_back(cfg_row(CFG_MODE, MODE_SCALE));
        dir_tab.push_back(cfg_row(CFG_SCALE, 64'h8000_0000_7FFF_FFFF));
        dir_tab.push_back(pt_row(32'h0000_3000, 32'hFFFF_E001, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(pt_row(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        // affine with skew
        dir_tab.push_back(cfg_row(CFG_SKEW, 64'h0000_8000_FFFF_0000));
        dir_tab.push_back(cfg_row(CFG_MODE, MODE_AFFINE));
        dir_tab.push_back(pt_row(32'h0002_8000, 32'hFFF3_0001, 0, 0, 0, 0, 0, 0));
        // perspective, zero w from a zero row
        dir_tab.push_back(cfg_row(CFG_MODE, MODE_PERSPECTIVE));
        dir_tab.push_back(cfg_row(CFG_PERSP, 64'h0));
        dir_tab.push_back(cfg_row(CFG_BIAS, 64'h0));
        dir_tab.push_back(pt_row(32'h0001_2345, 32'hFFFF_FFFF, 1, 1, 32'h0, 32'h0, 1, 0));
        dir_tab.push_back(cfg_row(CFG_BIAS, 64'h7FFF_FFFF));
        dir_tab.push_back(pt_row(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        // perspective, w cancels to zero at this point
        dir_tab.push_back(cfg_row(CFG_PERSP, 64'h0001_0000_0001_0000));
        dir_tab.push_back(cfg_row(CFG_BIAS, 64'h8000_0000));
        dir_tab.push_back(pt_row(32'h4000_0000, 32'h4000_0000, 0, 1, 32'h0, 32'h0, 1, 0));
        dir_tab.push_back(pt_row(32'h0001_0000, 32'h0001_0000, 1, 0, 0, 0, 0, 0));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                drain_pipe();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].last, dir_tab[i].typed,
                           dir_tab[i].res);
            end
        end

        // random groups, each with a fresh matrix
        for (int g = 0; g < 14; g++) begin
            point_res_t none;
            none = '{default: '0};
            drain_pipe();
            if (g < 5) begin
                send_idle_pct = 35;
                recv_idle_pct = 57;
            end else if (g < 10) begin
                send_idle_pct = 57;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_MODE, 64'($urandom_range(0, 3)));
            write_reg(CFG_SCALE, {rand_q(), rand_q()});
            write_reg(CFG_SKEW, {rand_q(), rand_q()});
            write_reg(CFG_TRANSLATE, {rand_q(), rand_q()});
            write_reg(CFG_PERSP, {rand_q(), rand_q()});
            write_reg(CFG_BIAS, 64'(rand_q()));
            for (int k = 0; k < 100; k++)
                send_point(rand_coord(), rand_coord(), ($urandom_range(0, 7) == 0), 0, none);
        end

        drain_pipe();
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #60ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
sv/ppt_pkg.sv
sv/ppt_div.sv
sv/point_projective_transform.sv
dv/point_projective_transform_test.sv
